// ===== hw/rtl/tpt_pkg.sv =====
// tpt_pkg: shared widths, codes and reset values for the peer timer machine
// no dependencies; imported by tunnel_peer_timer_machine
`default_nettype none

package tpt_pkg;

	// field and register widths
	localparam int ACT_W      = 4;
	localparam int RND_W      = 32;
	localparam int CMD_W      = 3;
	localparam int ATT_W      = 6;
	localparam int CFG_W      = 28;
	localparam int JIT_W      = 16;
	localparam int MAXHS_W    = 5;
	localparam int IDX_W      = 3;
	localparam int NUM_TIMERS = 5;
	// widest computed delay: keepalive + rekey + jitter
	localparam int DELAY_W    = CFG_W + 2;

	localparam int TIMER_BITS_DEF = 32;

	// action codes
	localparam logic [ACT_W-1:0] ACT_TICK       = 4'd0;
	localparam logic [ACT_W-1:0] ACT_DATA_SENT  = 4'd1;
	localparam logic [ACT_W-1:0] ACT_DATA_RECV  = 4'd2;
	localparam logic [ACT_W-1:0] ACT_AUTH_SENT  = 4'd3;
	localparam logic [ACT_W-1:0] ACT_AUTH_RECV  = 4'd4;
	localparam logic [ACT_W-1:0] ACT_HS_INIT    = 4'd5;
	localparam logic [ACT_W-1:0] ACT_HS_DONE    = 4'd6;
	localparam logic [ACT_W-1:0] ACT_SESSION    = 4'd7;
	localparam logic [ACT_W-1:0] ACT_TRAVERSAL  = 4'd8;
	localparam logic [ACT_W-1:0] ACT_STOP       = 4'd9;

	// command codes
	localparam logic [CMD_W-1:0] CMD_NONE      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INITIATE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_KEEPALIVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PURGE     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ZERO_KEYS = 3'd4;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_DEVICE_UP  = 3'd0;
	localparam logic [IDX_W-1:0] REG_REKEY      = 3'd1;
	localparam logic [IDX_W-1:0] REG_KEEPALIVE  = 3'd2;
	localparam logic [IDX_W-1:0] REG_ZERO_KEY   = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAX_HS     = 3'd4;
	localparam logic [IDX_W-1:0] REG_JITTER     = 3'd5;
	localparam logic [IDX_W-1:0] REG_PERSISTENT = 3'd6;

	// configuration reset values
	localparam logic [CFG_W-1:0]   RST_REKEY      = 28'd5000;
	localparam logic [CFG_W-1:0]   RST_KEEPALIVE  = 28'd10000;
	localparam logic [CFG_W-1:0]   RST_ZERO_KEY   = 28'd540000;
	localparam logic [MAXHS_W-1:0] RST_MAX_HS     = 5'd18;
	localparam logic [JIT_W-1:0]   RST_JITTER     = 16'd333;
	localparam logic [CFG_W-1:0]   RST_PERSISTENT = 28'd0;

	// timer slots, also the order of results within one tick
	localparam int T_RETX    = 0;
	localparam int T_KEEP    = 1;
	localparam int T_NEWHS   = 2;
	localparam int T_ZERO    = 3;
	localparam int T_PERSIST = 4;

	localparam logic [ATT_W-1:0] ATT_MAX = '1;

endpackage

`default_nettype wire

// ===== hw/rtl/tunnel_peer_timer_machine.sv =====
// tunnel_peer_timer_machine: five countdown timers of one tunnel peer
// an item is registered with its jitter product, then one pass updates the timers
// and loads a result buffer that drains one result per cycle while out_ready is high;
// depends on tpt_pkg
// an item passes the input-stage register, then the result buffer offers its results
// throughput: one item per cycle while the result buffer is free; a tick with more than
// one result holds the input while the buffer drains, set by the single result register
// reset: arst_n clears timers, pending and follow-up flags, attempt count and valid bits
// at once and loads the configuration registers with their reset values
`default_nettype none

module tunnel_peer_timer_machine
	import tpt_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	// configuration write port
	input  wire                 cfg_write,
	input  wire [IDX_W-1:0]     cfg_index,
	input  wire [CFG_W-1:0]     cfg_data,
	// input channel
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire [ACT_W-1:0]     action,
	input  wire [RND_W-1:0]     random_word,
	// result channel
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [CMD_W-1:0]    command,
	output logic                is_retry,
	output logic                clear_source,
	output logic [ATT_W-1:0]    attempt_count,
	output logic                last
);

	localparam int WW = (DELAY_W > TIMER_BITS) ? DELAY_W : TIMER_BITS;
	localparam logic [WW:0] TLIM = (WW+1)'(1) << TIMER_BITS;

	typedef logic [TIMER_BITS-1:0] timer_t;

	// clamp a delay into the timer range and raise zero to one
	function automatic timer_t fit_delay(input logic [DELAY_W-1:0] d);
		logic [WW:0] dw;
		timer_t      r;
		dw = (WW+1)'(d);
		if (dw >= TLIM) begin
			r = '1;
		end else begin
			r = dw[TIMER_BITS-1:0];
		end
		if (r == '0) begin
			r = TIMER_BITS'(1);
		end
		return r;
	endfunction

	// configuration registers
	logic               device_up_q;
	logic [CFG_W-1:0]   rekey_q;
	logic [CFG_W-1:0]   keepalive_q;
	logic [CFG_W-1:0]   zero_key_q;
	logic [MAXHS_W-1:0] max_hs_q;
	logic [JIT_W-1:0]   jitter_range_q;
	logic [CFG_W-1:0]   persistent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_up_q    <= 1'b0;
			rekey_q        <= RST_REKEY;
			keepalive_q    <= RST_KEEPALIVE;
			zero_key_q     <= RST_ZERO_KEY;
			max_hs_q       <= RST_MAX_HS;
			jitter_range_q <= RST_JITTER;
			persistent_q   <= RST_PERSISTENT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEVICE_UP:  device_up_q    <= cfg_data[0];
				REG_REKEY:      rekey_q        <= cfg_data;
				REG_KEEPALIVE:  keepalive_q    <= cfg_data;
				REG_ZERO_KEY:   zero_key_q     <= cfg_data;
				REG_MAX_HS:     max_hs_q       <= cfg_data[MAXHS_W-1:0];
				REG_JITTER:     jitter_range_q <= cfg_data[JIT_W-1:0];
				REG_PERSISTENT: persistent_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage: action and jitter product
	logic                     valid_s1;
	logic [ACT_W-1:0]         action_s1;
	logic [JIT_W-1:0]         jitter_s1;
	logic [RND_W+JIT_W-1:0]   jit_prod;
	logic                     adv_s1;
	logic                     buf_free;

	// result buffer: one bit per pending result in emission order
	logic [NUM_TIMERS-1:0]    res_mask_q;
	logic                     giveup_q;
	logic [ATT_W-1:0]         res_att_q;
	logic                     out_take;
	logic                     res_last;

	assign jit_prod = (RND_W+JIT_W)'(random_word) * (RND_W+JIT_W)'(jitter_range_q);
	assign res_last = (res_mask_q & (res_mask_q - NUM_TIMERS'(1))) == '0;
	assign out_take = out_valid && out_ready;
	assign buf_free = (res_mask_q == '0) || (out_ready && res_last);
	assign adv_s1   = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			jitter_s1 <= jit_prod[RND_W+JIT_W-1:RND_W];
		end
	end

	// timer state
	timer_t                left_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] pend_q;
	logic [ATT_W-1:0]      attempts_q;
	logic                  another_q;

	timer_t                left_n [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] pend_n;
	logic [ATT_W-1:0]      attempts_n;
	logic                  another_n;
	logic [NUM_TIMERS-1:0] res_n;
	logic                  giveup_n;
	logic [NUM_TIMERS-1:0] expired;
	timer_t                dec;
	logic [DELAY_W-1:0]    d_newhs;
	logic [DELAY_W-1:0]    d_retx;

	assign d_newhs = DELAY_W'(keepalive_q) + DELAY_W'(rekey_q) + DELAY_W'(jitter_s1);
	assign d_retx  = DELAY_W'(rekey_q) + DELAY_W'(jitter_s1);

	// next timer state and result set for the item in the input stage
	always_comb begin
		left_n     = left_q;
		pend_n     = pend_q;
		attempts_n = attempts_q;
		another_n  = another_q;
		res_n      = '0;
		giveup_n   = 1'b0;
		expired    = '0;
		dec        = '0;
		unique case (action_s1)
			ACT_TICK: begin
				// count down every pending timer
				for (int k = 0; k < NUM_TIMERS; k++) begin
					if (pend_q[k]) begin
						dec = left_q[k] - TIMER_BITS'(left_q[k] != '0);
						left_n[k] = dec;
						if (dec == '0) begin
							expired[k] = 1'b1;
							pend_n[k]  = 1'b0;
						end
					end
				end
				// retransmit expiry: retry or give up
				if (expired[T_RETX]) begin
					res_n[T_RETX] = 1'b1;
					if (attempts_q > ATT_W'(max_hs_q)) begin
						giveup_n        = 1'b1;
						pend_n[T_KEEP]  = 1'b0;
						left_n[T_KEEP]  = '0;
						expired[T_KEEP] = 1'b0;
						if (!pend_n[T_ZERO] && device_up_q) begin
							left_n[T_ZERO] = fit_delay(DELAY_W'(zero_key_q));
							pend_n[T_ZERO] = 1'b1;
						end
					end else if (attempts_q != ATT_MAX) begin
						attempts_n = attempts_q + ATT_W'(1);
					end
				end
				// keepalive expiry, with a queued follow-up
				if (expired[T_KEEP]) begin
					res_n[T_KEEP] = 1'b1;
					if (another_q) begin
						another_n = 1'b0;
						if (device_up_q) begin
							left_n[T_KEEP] = fit_delay(DELAY_W'(keepalive_q));
							pend_n[T_KEEP] = 1'b1;
						end
					end
				end
				res_n[T_NEWHS]   = expired[T_NEWHS];
				res_n[T_ZERO]    = expired[T_ZERO];
				res_n[T_PERSIST] = expired[T_PERSIST] && (persistent_q != '0);
			end
			ACT_DATA_SENT: begin
				if (!pend_q[T_NEWHS] && device_up_q) begin
					left_n[T_NEWHS] = fit_delay(d_newhs);
					pend_n[T_NEWHS] = 1'b1;
				end
			end
			ACT_DATA_RECV: begin
				if (device_up_q) begin
					if (!pend_q[T_KEEP]) begin
						left_n[T_KEEP] = fit_delay(DELAY_W'(keepalive_q));
						pend_n[T_KEEP] = 1'b1;
					end else begin
						another_n = 1'b1;
					end
				end
			end
			ACT_AUTH_SENT: begin
				pend_n[T_KEEP] = 1'b0;
				left_n[T_KEEP] = '0;
			end
			ACT_AUTH_RECV: begin
				pend_n[T_NEWHS] = 1'b0;
				left_n[T_NEWHS] = '0;
			end
			ACT_HS_INIT: begin
				if (device_up_q) begin
					left_n[T_RETX] = fit_delay(d_retx);
					pend_n[T_RETX] = 1'b1;
				end
			end
			ACT_HS_DONE: begin
				pend_n[T_RETX] = 1'b0;
				left_n[T_RETX] = '0;
				attempts_n     = '0;
			end
			ACT_SESSION: begin
				if (device_up_q) begin
					left_n[T_ZERO] = fit_delay(DELAY_W'(zero_key_q));
					pend_n[T_ZERO] = 1'b1;
				end
			end
			ACT_TRAVERSAL: begin
				if (device_up_q && persistent_q != '0) begin
					left_n[T_PERSIST] = fit_delay(DELAY_W'(persistent_q));
					pend_n[T_PERSIST] = 1'b1;
				end
			end
			ACT_STOP: begin
				pend_n = '0;
				for (int k = 0; k < NUM_TIMERS; k++) begin
					left_n[k] = '0;
				end
			end
			default: ;
		endcase
	end

	// commit the state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_TIMERS; k++) begin
				left_q[k] <= '0;
			end
			pend_q     <= '0;
			attempts_q <= '0;
			another_q  <= 1'b0;
		end else if (adv_s1) begin
			left_q     <= left_n;
			pend_q     <= pend_n;
			attempts_q <= attempts_n;
			another_q  <= another_n;
		end
	end

	// result buffer load and drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_mask_q <= '0;
		end else if (adv_s1) begin
			res_mask_q <= res_n;
		end else if (out_take) begin
			res_mask_q <= res_mask_q & (res_mask_q - NUM_TIMERS'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			giveup_q  <= giveup_n;
			res_att_q <= attempts_n;
		end
	end

	// present the earliest pending result
	assign out_valid     = res_mask_q != '0;
	assign attempt_count = res_att_q;
	assign last          = res_last;

	always_comb begin
		command      = CMD_NONE;
		is_retry     = 1'b0;
		clear_source = 1'b0;
		priority if (res_mask_q[T_RETX]) begin
			command      = giveup_q ? CMD_PURGE : CMD_INITIATE;
			is_retry     = !giveup_q;
			clear_source = !giveup_q;
		end else if (res_mask_q[T_KEEP]) begin
			command = CMD_KEEPALIVE;
		end else if (res_mask_q[T_NEWHS]) begin
			command      = CMD_INITIATE;
			clear_source = 1'b1;
		end else if (res_mask_q[T_ZERO]) begin
			command = CMD_ZERO_KEYS;
		end else if (res_mask_q[T_PERSIST]) begin
			command = CMD_KEEPALIVE;
		end else begin
			command = CMD_NONE;
		end
	end

	// a pending retransmit timer always has ticks left
	a_pending_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q[T_RETX] |-> left_q[T_RETX] != '0)
		else $error("pending retransmit timer holds zero");

	// an event other than a tick leaves no result behind
	a_event_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && action_s1 != ACT_TICK) |=> !out_valid)
		else $error("non-tick item produced a result");

	// the last result drains the buffer unless a new item is loaded
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && last && !adv_s1) |=> !out_valid)
		else $error("result buffer not empty after last result");

	// while the device is down no timer becomes pending
	a_no_arm_down: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !device_up_q) |=> (pend_q & ~$past(pend_q)) == '0)
		else $error("timer armed while device down");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking bench for tunnel_peer_timer_machine, commands predicted per item
// drives protocol events and ticks over valid/ready and checks each command item in order
// depends on tpt_pkg and the rtl of tunnel_peer_timer_machine
`default_nettype none

module tb;
	import tpt_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNUSED_LO = ACT_STOP + 4'd1;
	localparam logic [ACT_W-1:0] ACT_UNUSED_HI = '1;
	localparam logic [CFG_W-1:0] CFG_TOP = '1;
	localparam logic [63:0] TIMER_MAX = (64'd1 << TIMER_BITS_DEF) - 64'd1;
	localparam int DRAIN_CYCLES = 6;
	localparam int RANDOM_EVENTS = 380;
	localparam int CALM_EVENTS = 60;
	localparam int PHASE_EVENTS = 40;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             is_retry;
		logic             clear_source;
		logic [ATT_W-1:0] attempt_count;
		logic             last;
	} command_item_t;

	// timer state copy and the queue of commands still owed by the block
	class timer_command_board;
		logic                      up;
		logic [CFG_W-1:0]          rekey_to, keep_to, zero_to, persist_iv;
		logic [MAXHS_W-1:0]        max_hs;
		logic [JIT_W-1:0]          jit_range;
		logic [TIMER_BITS_DEF-1:0] left [NUM_TIMERS];
		logic [NUM_TIMERS-1:0]     armed;
		logic [ATT_W-1:0]          tries;
		logic                      keep_again;
		command_item_t             expected_cmds [$];
		int                        errors;

		function new();
			up = 1'b0;
			rekey_to = RST_REKEY;
			keep_to = RST_KEEPALIVE;
			zero_to = RST_ZERO_KEY;
			max_hs = RST_MAX_HS;
			jit_range = RST_JITTER;
			persist_iv = RST_PERSISTENT;
			foreach (left[i]) left[i] = '0;
			armed = '0;
			tries = '0;
			keep_again = 1'b0;
			errors = 0;
		endfunction

		function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_DEVICE_UP:  up = data[0];
				REG_REKEY:      rekey_to = data;
				REG_KEEPALIVE:  keep_to = data;
				REG_ZERO_KEY:   zero_to = data;
				REG_MAX_HS:     max_hs = data[MAXHS_W-1:0];
				REG_JITTER:     jit_range = data[JIT_W-1:0];
				REG_PERSISTENT: persist_iv = data;
				default: ;
			endcase
		endfunction

		// arming is dropped while the device is down; delay clamped to 1..max
		function void arm_timer(int slot, logic [63:0] delay);
			if (!up)
				return;
			if (delay > TIMER_MAX)
				delay = TIMER_MAX;
			if (delay == 64'd0)
				delay = 64'd1;
			left[slot] = delay[TIMER_BITS_DEF-1:0];
			armed[slot] = 1'b1;
		endfunction

		function void cancel_timer(int slot);
			armed[slot] = 1'b0;
			left[slot] = '0;
		endfunction

		function logic [63:0] jitter_of(logic [RND_W-1:0] rnd);
			return (64'(rnd) * 64'(jit_range)) >> 32;
		endfunction

		function void owe_command(logic [CMD_W-1:0] cmd, logic retry, logic clr);
			command_item_t c;
			c.command = cmd;
			c.is_retry = retry;
			c.clear_source = clr;
			c.attempt_count = tries;
			c.last = 1'b0;
			expected_cmds.push_back(c);
		endfunction

		// update the timers for one accepted item and queue the commands it causes
		function void note_event(logic [ACT_W-1:0] act, logic [RND_W-1:0] rnd);
			logic [NUM_TIMERS-1:0] fired;
			int queued;
			int t;
			fired = '0;
			queued = expected_cmds.size();
			case (act)
				ACT_TICK: begin
					for (t = 0; t < NUM_TIMERS; t++) begin
						if (armed[t]) begin
							if (left[t] != '0)
								left[t] = left[t] - 1'b1;
							if (left[t] == '0) begin
								fired[t] = 1'b1;
								armed[t] = 1'b0;
							end
						end
					end
					// retransmit: retry or give up
					if (fired[T_RETX]) begin
						if (tries > max_hs) begin
							cancel_timer(T_KEEP);
							fired[T_KEEP] = 1'b0;
							owe_command(CMD_PURGE, 1'b0, 1'b0);
							if (!armed[T_ZERO])
								arm_timer(T_ZERO, 64'(zero_to));
						end else begin
							if (tries != ATT_MAX)
								tries = tries + 1'b1;
							owe_command(CMD_INITIATE, 1'b1, 1'b1);
						end
					end
					if (fired[T_KEEP]) begin
						owe_command(CMD_KEEPALIVE, 1'b0, 1'b0);
						if (keep_again) begin
							keep_again = 1'b0;
							arm_timer(T_KEEP, 64'(keep_to));
						end
					end
					if (fired[T_NEWHS])
						owe_command(CMD_INITIATE, 1'b0, 1'b1);
					if (fired[T_ZERO])
						owe_command(CMD_ZERO_KEYS, 1'b0, 1'b0);
					if (fired[T_PERSIST] && persist_iv != '0)
						owe_command(CMD_KEEPALIVE, 1'b0, 1'b0);
					if (expected_cmds.size() > queued)
						expected_cmds[expected_cmds.size() - 1].last = 1'b1;
				end
				ACT_DATA_SENT: begin
					if (!armed[T_NEWHS])
						arm_timer(T_NEWHS, 64'(keep_to) + 64'(rekey_to) + jitter_of(rnd));
				end
				ACT_DATA_RECV: begin
					if (up) begin
						if (!armed[T_KEEP])
							arm_timer(T_KEEP, 64'(keep_to));
						else
							keep_again = 1'b1;
					end
				end
				ACT_AUTH_SENT: cancel_timer(T_KEEP);
				ACT_AUTH_RECV: cancel_timer(T_NEWHS);
				ACT_HS_INIT: arm_timer(T_RETX, 64'(rekey_to) + jitter_of(rnd));
				ACT_HS_DONE: begin
					cancel_timer(T_RETX);
					tries = '0;
				end
				ACT_SESSION: arm_timer(T_ZERO, 64'(zero_to));
				ACT_TRAVERSAL: begin
					if (persist_iv != '0)
						arm_timer(T_PERSIST, 64'(persist_iv));
				end
				ACT_STOP: begin
					for (t = 0; t < NUM_TIMERS; t++)
						cancel_timer(t);
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		// compare one accepted command item with the oldest one owed
		task check_command(logic [CMD_W-1:0] cmd, logic retry, logic clr,
			logic [ATT_W-1:0] att, logic lst);
			command_item_t want;
			if (expected_cmds.size() == 0) begin
				report($sformatf("command %0d with nothing owed", cmd));
				return;
			end
			want = expected_cmds.pop_front();
			if (cmd !== want.command)
				report($sformatf("command %0d, want %0d", cmd, want.command));
			if (retry !== want.is_retry)
				report($sformatf("is_retry %0b, want %0b", retry, want.is_retry));
			if (clr !== want.clear_source)
				report($sformatf("clear_source %0b, want %0b", clr, want.clear_source));
			if (att !== want.attempt_count)
				report($sformatf("attempt_count %0d, want %0d", att, want.attempt_count));
			if (lst !== want.last)
				report($sformatf("last %0b, want %0b", lst, want.last));
		endtask
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_write = 1'b0;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [ACT_W-1:0]    action = '0;
	logic [RND_W-1:0]    random_word = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CMD_W-1:0]    command;
	logic                is_retry;
	logic                clear_source;
	logic [ATT_W-1:0]    attempt_count;
	logic                last;

	logic                calm = 1'b0;
	int                  events_sent = 0;
	int                  stall_left = 0;
	timer_command_board  board;

	tunnel_peer_timer_machine dut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	// result side stalls in bursts
	always @(posedge clk) begin
		if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 12);
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitors for both channels
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_event(action, random_word);
		if (arst_n && out_valid && out_ready)
			board.check_command(command, is_retry, clear_source, attempt_count, last);
	end

	// present one item, maybe after an idle burst, and wait for it to be taken
	task automatic send_event(input logic [ACT_W-1:0] act, input logic [RND_W-1:0] rnd);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		random_word <= rnd;
		do @(posedge clk); while (!in_ready);
		if (act <= ACT_STOP)
			events_sent++;
	endtask

	// stop sending and wait until every owed command has come out
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.expected_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.set_register(idx, data);
	endtask

	task automatic apply_config(input logic up, input logic [CFG_W-1:0] rekey,
		input logic [CFG_W-1:0] keepalive, input logic [CFG_W-1:0] zero_key,
		input logic [MAXHS_W-1:0] max_hs, input logic [JIT_W-1:0] jitter,
		input logic [CFG_W-1:0] persistent);
		write_reg(REG_DEVICE_UP, CFG_W'(up));
		write_reg(REG_REKEY, rekey);
		write_reg(REG_KEEPALIVE, keepalive);
		write_reg(REG_ZERO_KEY, zero_key);
		write_reg(REG_MAX_HS, CFG_W'(max_hs));
		write_reg(REG_JITTER, CFG_W'(jitter));
		write_reg(REG_PERSISTENT, persistent);
		cfg_write <= 1'b0;
	endtask

	// short timeouts so timers fire often; now and then a wide retry budget or jitter
	task automatic apply_random_config();
		logic [JIT_W-1:0]   jit;
		logic [MAXHS_W-1:0] hs;
		jit = ($urandom_range(0, 7) == 0) ? JIT_W'($urandom) : JIT_W'($urandom_range(0, 6));
		hs = ($urandom_range(0, 5) == 0) ? MAXHS_W'($urandom) : MAXHS_W'($urandom_range(0, 3));
		apply_config($urandom_range(0, 5) != 0, CFG_W'($urandom_range(1, 6)),
			CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 10)), hs, jit,
			CFG_W'($urandom_range(0, 5)));
	endtask

	function automatic logic [RND_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// traffic inside an established session, ticks weighted heavily
	function automatic logic [ACT_W-1:0] pick_traffic();
		case ($urandom_range(0, 11))
			6: return ACT_DATA_SENT;
			7: return ACT_DATA_RECV;
			8: return ACT_AUTH_SENT;
			9: return ACT_AUTH_RECV;
			10: return ACT_TRAVERSAL;
			11: return ACT_STOP;
			default: return ACT_TICK;
		endcase
	endfunction

	// handshake, ticks, usually completion and session, then traffic
	task automatic run_handshake_flow();
		send_event(ACT_HS_INIT, pick_word());
		repeat ($urandom_range(0, 6)) send_event(ACT_TICK, pick_word());
		if ($urandom_range(0, 4) != 0) begin
			send_event(ACT_HS_DONE, pick_word());
			send_event(ACT_SESSION, pick_word());
		end
		repeat ($urandom_range(2, 8)) send_event(pick_traffic(), pick_word());
	endtask

	// any action code at all, unused ones included
	task automatic run_noise();
		repeat ($urandom_range(1, 8))
			send_event(ACT_W'($urandom_range(0, 15)), pick_word());
	endtask

	initial begin
		int stop_at;
		int phase_end;
		int phase;
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// device down after reset: nothing arms, unused codes ignored
		send_event(ACT_DATA_RECV, '0);
		send_event(ACT_HS_INIT, '1);
		send_event(ACT_TICK, '0);
		send_event(ACT_UNUSED_LO, '0);
		send_event(ACT_UNUSED_HI, '1);
		settle();

		// every timer armed with short delays, expiries in one tick, then give-up
		apply_config(1'b1, 28'd2, 28'd3, 28'd4, 5'd0, 16'd0, 28'd2);
		send_event(ACT_HS_INIT, '0);
		send_event(ACT_DATA_RECV, '0);
		send_event(ACT_DATA_RECV, '0);
		send_event(ACT_SESSION, '0);
		send_event(ACT_TRAVERSAL, '0);
		send_event(ACT_DATA_SENT, '1);
		repeat (4) send_event(ACT_TICK, '0);
		send_event(ACT_HS_INIT, '0);
		repeat (2) send_event(ACT_TICK, '0);
		send_event(ACT_AUTH_SENT, '0);
		send_event(ACT_AUTH_RECV, '0);
		send_event(ACT_HS_DONE, '0);
		send_event(ACT_STOP, '0);
		settle();

		// persistent timer running when its interval drops to zero
		apply_config(1'b1, 28'd2, 28'd3, 28'd4, 5'd0, 16'd0, 28'd3);
		send_event(ACT_TRAVERSAL, '0);
		settle();
		apply_config(1'b1, 28'd2, 28'd3, 28'd4, 5'd0, 16'd0, 28'd0);
		repeat (3) send_event(ACT_TICK, '0);
		send_event(ACT_TRAVERSAL, '0);

		// random phases, each under a fresh setting
		stop_at = events_sent + RANDOM_EVENTS;
		phase = 0;
		while (events_sent < stop_at) begin
			settle();
			case (phase)
				1: apply_config(1'b1, CFG_TOP, CFG_TOP, CFG_TOP, '1, '1, CFG_TOP);
				2: apply_config(1'b1, 28'd1, 28'd1, 28'd1, '0, '0, 28'd1);
				default: apply_random_config();
			endcase
			phase++;
			phase_end = events_sent + PHASE_EVENTS;
			while (events_sent < phase_end && events_sent < stop_at) begin
				calm = (events_sent >= stop_at - CALM_EVENTS);
				if ($urandom_range(0, 9) < 7)
					run_handshake_flow();
				else
					run_noise();
			end
		end
		settle();

		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/tpt_pkg.sv
hw/rtl/tunnel_peer_timer_machine.sv
sim/tb.sv
